// ===== rtl/core/bmhq_pkg.sv =====
// Package for the binary min-heap queue: sizes, operation and status codes,
// and the heap index helpers.
// No dependencies.
`timescale 1ns / 1ps

package bmhq_pkg;

  // Heap capacity and the widths that follow from it
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CHILD_W  = ADDR_W + 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STAT_W   = 2;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CHILD_W-1:0]      child_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Parent slot of a non-root slot
  function automatic addr_t parent_of(addr_t p);
    addr_t pm1;
    pm1 = p - addr_t'(1);
    return pm1 >> 1;
  endfunction

  // Left child slot, wide enough to sit past the last slot
  function automatic child_t left_of(addr_t p);
    return {1'b0, p, 1'b1};
  endfunction

endpackage

// ===== rtl/core/bmhq_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, read data registered.
// No dependencies.
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/core/binary_min_heap_queue.sv =====
// Binary min-heap priority queue of signed 32-bit keys held in a 2-read/1-write RAM.
// A refused insert (full) or extract (empty) goes from acceptance straight to the result
// state; any other insert or extract first reads the RAM and sifts the heap.
// The sift walks one heap level per cycle, paced by the RAM's registered read.
// One transaction is in flight at a time; the next is accepted the cycle after the result
// loads into the output register, later while an earlier result is still held there.
// Reset (rst_ni low, asynchronous) empties the heap; the key store itself is not cleared.
// Depends on bmhq_pkg and bmhq_ram.
`timescale 1ns / 1ps

module binary_min_heap_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic signed [bmhq_pkg::KEY_W-1:0] key_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [bmhq_pkg::KEY_W-1:0] key_out_o,
  output logic [bmhq_pkg::STAT_W-1:0]      status_o,
  output logic [bmhq_pkg::CNT_W-1:0]       count_o
);

  import bmhq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXLOAD = 6'b000010,
    S_UPCMP  = 6'b000100,
    S_DNCMP  = 6'b001000,
    S_FIN    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e  state_q, state_d;
  cnt_t    cnt_q, cnt_d;
  addr_t   pos_q, pos_d;
  key_t    key_q, key_d;
  key_t    res_key_q, res_key_d;
  status_e res_status_q, res_status_d;
  logic    out_valid_q, out_valid_d;
  key_t    out_key_q;
  status_e out_status_q;
  cnt_t    out_count_q;
  logic    out_load;

  // RAM port signals
  logic  mem_we;
  addr_t mem_waddr;
  key_t  mem_wdata;
  addr_t mem_raddr_a, mem_raddr_b;
  logic [KEY_W-1:0] mem_rdata_a, mem_rdata_b;
  key_t  rd_a, rd_b;

  // Sift helpers
  addr_t  up_pos;
  child_t lc, rc, nlc, nrc;
  child_t root_lc, root_rc;
  logic   l_take, r_take, moved;
  key_t   l_best;
  addr_t  best_pos;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;
  assign rd_a   = $signed(mem_rdata_a);
  assign rd_b   = $signed(mem_rdata_b);

  bmhq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // Sift-up: parent of the hole; sift-down: smaller child strictly below the key
  always_comb begin
    up_pos   = parent_of(pos_q);
    lc       = left_of(pos_q);
    rc       = lc + child_t'(1);
    l_take   = (lc < child_t'(cnt_q)) && (rd_a < key_q);
    l_best   = l_take ? rd_a : key_q;
    r_take   = (rc < child_t'(cnt_q)) && (rd_b < l_best);
    moved    = l_take || r_take;
    best_pos = r_take ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
    nlc      = left_of(best_pos);
    nrc      = nlc + child_t'(1);
    root_lc  = left_of('0);
    root_rc  = root_lc + child_t'(1);
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    key_d        = key_q;
    res_key_d    = res_key_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = key_q;
    mem_raddr_a  = '0;
    mem_raddr_b  = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_key_d    = '0;
          res_status_d = ST_OK;
          if (op_i == OP_INSERT) begin
            if (cnt_q >= cnt_t'(CAPACITY)) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end else begin
              pos_d       = cnt_q[ADDR_W-1:0];
              key_d       = key_in_i;
              cnt_d       = cnt_q + cnt_t'(1);
              mem_raddr_a = parent_of(cnt_q[ADDR_W-1:0]);
              state_d     = (cnt_q == '0) ? S_FIN : S_UPCMP;
            end
          end else begin
            if (cnt_q == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              cnt_d       = cnt_q - cnt_t'(1);
              mem_raddr_a = '0;
              mem_raddr_b = addr_t'(cnt_q - cnt_t'(1));
              state_d     = S_EXLOAD;
            end
          end
        end
      end

      // Root is the result; the last entry becomes the key to sift down
      S_EXLOAD: begin
        res_key_d   = rd_a;
        key_d       = rd_b;
        pos_d       = '0;
        mem_raddr_a = root_lc[ADDR_W-1:0];
        mem_raddr_b = root_rc[ADDR_W-1:0];
        state_d     = (cnt_q == '0) ? S_DONE : S_DNCMP;
      end

      // One level up per cycle: move the parent into the hole or stop
      S_UPCMP: begin
        mem_we = 1'b1;
        if (key_q < rd_a) begin
          mem_wdata   = rd_a;
          pos_d       = up_pos;
          mem_raddr_a = parent_of(up_pos);
          state_d     = (up_pos == '0) ? S_FIN : S_UPCMP;
        end else begin
          state_d = S_DONE;
        end
      end

      // One level down per cycle: move the smaller child into the hole or stop
      S_DNCMP: begin
        mem_we = 1'b1;
        if (moved) begin
          mem_wdata   = r_take ? rd_b : rd_a;
          pos_d       = best_pos;
          mem_raddr_a = nlc[ADDR_W-1:0];
          mem_raddr_b = nrc[ADDR_W-1:0];
        end else begin
          state_d = S_DONE;
        end
      end

      S_FIN: begin
        mem_we  = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    key_q        <= key_d;
    res_key_q    <= res_key_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_key_q    <= res_key_q;
      out_status_q <= res_status_q;
      out_count_q  <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_out_o   = out_key_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(CAPACITY))
    else $error("entry count beyond capacity");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (cnt_t'(mem_waddr) < cnt_q))
    else $error("key store write outside the live heap");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted transaction not started");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_FULL) |-> (out_count_q == cnt_t'(CAPACITY)))
    else $error("full status with heap not full");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |-> (out_count_q == '0 && out_key_q == '0))
    else $error("empty status with keys held or key returned");

endmodule

// ===== test/binary_min_heap_queue_tb.sv =====
// Testbench for binary_min_heap_queue: drives insert and extract-min transactions
// and checks every result against a heap model kept inside the bench.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL.
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;

  import bmhq_pkg::*;

  typedef struct {
    key_t    key;
    status_e status;
    cnt_t    count;
  } heap_result_t;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_ready_o;
  logic         op_i;
  key_t         key_in_i;
  logic         out_valid_o;
  logic         out_ready_i;
  key_t         key_out_o;
  logic [STAT_W-1:0] status_o;
  logic [CNT_W-1:0]  count_o;

  // Heap model and the results it has predicted but not yet seen
  key_t         heap_keys [CAPACITY];
  int unsigned  heap_size;
  heap_result_t pending_results [$];
  heap_result_t oldest_result;

  int unsigned  err_count;
  bit           burst_mode;
  bit           stall_hold_req;

  binary_min_heap_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .key_in_i    (key_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_out_o   (key_out_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // Apply one operation to the model heap and return the result it gives
  function automatic heap_result_t predict_heap_op(op_e op, key_t key);
    heap_result_t res;
    int unsigned  pos;
    int unsigned  up;
    int unsigned  lc;
    int unsigned  rc;
    int unsigned  best;
    key_t         tmp;
    res.key    = '0;
    res.status = ST_OK;
    if (op == OP_INSERT) begin
      if (heap_size >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = heap_size;
        heap_keys[pos] = key;
        heap_size++;
        // sift up, stopping on an equal parent
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[pos] < heap_keys[up])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[up];
          heap_keys[up] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_size == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.key = heap_keys[0];
        heap_size--;
        heap_keys[0] = heap_keys[heap_size];
        pos = 0;
        // sift down towards the smaller child, left one on a tie
        forever begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          best = pos;
          if (lc < heap_size && heap_keys[lc] < heap_keys[best]) best = lc;
          if (rc < heap_size && heap_keys[rc] < heap_keys[best]) best = rc;
          if (best == pos) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[best];
          heap_keys[best] = tmp;
          pos = best;
        end
      end
    end
    res.count = cnt_t'(heap_size);
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Keys: full range mostly, a narrow band for duplicates, and the extremes
  function automatic key_t pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return key_t'($urandom());
    if (r < 90) return key_t'($signed($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 3))
      0:       return key_t'(32'h7fff_ffff);
      1:       return key_t'(32'h8000_0000);
      2:       return key_t'(32'h7fff_fffe);
      default: return key_t'(32'h8000_0001);
    endcase
  endfunction

  task automatic record_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      record_error($sformatf("%s mismatch: expected 0x%08h, got 0x%08h", field, want, got));
  endtask

  // Send one transaction, after a random idle gap
  task automatic send_heap_op(op_e op, key_t key);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_in_i   <= key;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_heap_op(op, key));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_heap_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Empty heap, both extremes, duplicates and an extract past the last key
  task automatic test_directed_cases();
    send_heap_op(OP_EXTRACT, key_t'(32'h1234_5678));
    send_heap_op(OP_INSERT, key_t'(32'h7fff_ffff));
    send_heap_op(OP_INSERT, key_t'(32'h8000_0000));
    send_heap_op(OP_INSERT, key_t'(0));
    send_heap_op(OP_INSERT, key_t'(-1));
    send_heap_op(OP_INSERT, key_t'(1));
    send_heap_op(OP_INSERT, key_t'(7));
    send_heap_op(OP_INSERT, key_t'(7));
    send_heap_op(OP_INSERT, key_t'(7));
    send_heap_op(OP_INSERT, key_t'(32'h8000_0000));
    for (int i = 0; i < 10; i++) send_heap_op(OP_EXTRACT, key_t'($urandom()));
    wait_heap_idle();
  endtask

  // Fill past capacity with the receiver held off, then drain past empty
  task automatic test_fill_and_drain();
    stall_hold_req = 1'b1;
    for (int i = 0; i < CAPACITY + 2; i++) send_heap_op(OP_INSERT, pick_key());
    for (int i = 0; i < CAPACITY + 2; i++) send_heap_op(OP_EXTRACT, key_t'($urandom()));
    wait_heap_idle();
  endtask

  // Mixed traffic; the insert share per segment drives the fill level around
  task automatic test_random_traffic();
    int unsigned ins_pct [7] = '{80, 50, 20, 95, 5, 60, 40};
    int unsigned pct;
    for (int seg = 0; seg < 17; seg++) begin
      pct = ins_pct[seg % 7];
      burst_mode = (seg % 4 == 3);
      if (seg == 8) stall_hold_req = 1'b1;
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 99) < pct) send_heap_op(OP_INSERT, pick_key());
        else send_heap_op(OP_EXTRACT, key_t'($urandom()));
      end
      if (seg % 5 == 4) wait_heap_idle();
    end
    burst_mode = 1'b0;
  endtask

  // Receiver: random ready streaks, plus a long hold-off on request
  initial begin
    int unsigned streak;
    out_ready_i <= 1'b0;
    streak = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_hold_req) begin
        out_ready_i <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk_i);
        stall_hold_req = 1'b0;
        streak = 0;
      end else if (burst_mode) begin
        out_ready_i <= 1'b1;
        streak = 0;
      end else if (streak > 0) begin
        streak--;
      end else if (!out_ready_i) begin
        out_ready_i <= 1'b1;
        streak = $urandom_range(0, 11);
      end else begin
        streak = pick_gap();
        if (streak > 0) begin
          out_ready_i <= 1'b0;
          streak--;
        end
      end
    end
  end

  // Result checker: each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        record_error($sformatf("unexpected result: key 0x%08h status %0d count %0d",
                               key_out_o, status_o, count_o));
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("key_out", oldest_result.key, key_out_o);
        check_field("status", 32'(oldest_result.status), 32'(status_o));
        check_field("count", 32'(oldest_result.count), 32'(count_o));
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    op_i        <= OP_INSERT;
    key_in_i    <= '0;
    heap_size      = 0;
    err_count      = 0;
    burst_mode     = 1'b0;
    stall_hold_req = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_fill_and_drain();
    test_random_traffic();

    wait_heap_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
